[sv/fbq_pkg.sv]
// ----------------------------------------------------------------------------
// fbq_pkg
// Shared types and constants of the fixed-point biquad IIR filter.
// ----------------------------------------------------------------------------
package fbq_pkg;

   localparam int DEFAULT_INPUT_WIDTH = 32;
   localparam int SAMPLE_W            = 32;
   localparam int COEF_W              = 16;
   localparam int OUT_W               = 16;
   localparam int CSR_IDX_W           = 3;

   localparam int SHIFT_B0 = 24;
   localparam int SHIFT_B1 = 23;
   localparam int SHIFT_B2 = 24;
   localparam int SHIFT_A1 = 14;
   localparam int SHIFT_A2 = 15;

   localparam logic [COEF_W-1:0] RST_B0       = 16'h76B0;
   localparam logic [COEF_W-1:0] RST_B1       = 16'h76B0;
   localparam logic [COEF_W-1:0] RST_B2       = 16'h76B0;
   localparam logic [COEF_W-1:0] RST_A1       = 16'h74A7;
   localparam logic [COEF_W-1:0] RST_A2       = 16'h94D7;
   localparam logic [OUT_W-1:0]  RST_INIT_OUT = 16'hC000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_B0       = 3'd0,
      CSR_B1       = 3'd1,
      CSR_B2       = 3'd2,
      CSR_A1       = 3'd3,
      CSR_A2       = 3'd4,
      CSR_INIT_OUT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_type;

   typedef struct packed {
      logic                    load;
      logic signed [OUT_W-1:0] value;
   } preset_type;

endpackage

[sv/fbq_csr.sv]
// ----------------------------------------------------------------------------
// fbq_csr
// Coefficient registers and preset strobe behind the write-only config port.
// ----------------------------------------------------------------------------
module fbq_csr
   import fbq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata,
   output coef_type             coef,
   output preset_type           preset
);

   coef_type coef_ff;
   coef_type coef_in;
   logic     preset_load;

   always_comb begin
      coef_in     = coef_ff;
      preset_load = 1'b0;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_B0:       coef_in.b0  = csr_wdata;
            CSR_B1:       coef_in.b1  = csr_wdata;
            CSR_B2:       coef_in.b2  = csr_wdata;
            CSR_A1:       coef_in.a1  = csr_wdata;
            CSR_A2:       coef_in.a2  = csr_wdata;
            CSR_INIT_OUT: preset_load = 1'b1;
            default:      coef_in     = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= RST_B0;
         coef_ff.b1 <= RST_B1;
         coef_ff.b2 <= RST_B2;
         coef_ff.a1 <= RST_A1;
         coef_ff.a2 <= RST_A2;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef         = coef_ff;
   assign preset.load  = preset_load;
   assign preset.value = csr_wdata;

endmodule

[sv/fbq_dp.sv]
// ----------------------------------------------------------------------------
// fbq_dp
// Filter history and the single-pass sum of five rounded, shifted products.
// ----------------------------------------------------------------------------
module fbq_dp
   import fbq_pkg::*;
#(
   parameter int INPUT_WIDTH = DEFAULT_INPUT_WIDTH
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic signed [INPUT_WIDTH-1:0] x,
   input  coef_type                      coef,
   input  preset_type                    preset,
   output logic        [OUT_W-1:0]       y
);

   localparam int PROD_W = INPUT_WIDTH + COEF_W;
   localparam int MIN_W  = SHIFT_B0 + OUT_W;
   localparam int WIDE_W = (PROD_W > MIN_W) ? PROD_W : MIN_W;
   localparam int FB_W   = COEF_W + OUT_W;

   logic signed [INPUT_WIDTH-1:0] xd1_ff, xd2_ff;
   logic signed [OUT_W-1:0]       yd1_ff, yd2_ff;

   logic signed [PROD_W-1:0] p0, p1, p2;
   logic signed [WIDE_W-1:0] w0, w1, w2;
   logic signed [FB_W-1:0]   q1, q2, v1, v2;
   logic        [OUT_W-1:0]  t0, t1, t2, t3, t4;

   assign p0 = $signed(coef.b0) * x;
   assign p1 = $signed(coef.b1) * xd1_ff;
   assign p2 = $signed(coef.b2) * xd2_ff;

   // add the half-step bias, then keep the 16 bits that survive the wrap
   assign w0 = WIDE_W'(p0) + (WIDE_W'(1) <<< (SHIFT_B0 - 1));
   assign w1 = WIDE_W'(p1) + (WIDE_W'(1) <<< (SHIFT_B1 - 1));
   assign w2 = WIDE_W'(p2) + (WIDE_W'(1) <<< (SHIFT_B2 - 1));

   assign q1 = $signed(coef.a1) * yd1_ff;
   assign q2 = $signed(coef.a2) * yd2_ff;
   assign v1 = q1 + (FB_W'(1) <<< (SHIFT_A1 - 1));
   assign v2 = q2 + (FB_W'(1) <<< (SHIFT_A2 - 1));

   assign t0 = w0[SHIFT_B0 +: OUT_W];
   assign t1 = w1[SHIFT_B1 +: OUT_W];
   assign t2 = w2[SHIFT_B2 +: OUT_W];
   assign t3 = v1[SHIFT_A1 +: OUT_W];
   assign t4 = v2[SHIFT_A2 +: OUT_W];

   assign y = t0 + t1 + t2 + t3 + t4;

   always_ff @(posedge clock) begin
      if (reset) begin
         xd1_ff <= '0;
         xd2_ff <= '0;
         yd1_ff <= RST_INIT_OUT;
         yd2_ff <= RST_INIT_OUT;
      end else if (preset.load) begin
         yd1_ff <= preset.value;
         yd2_ff <= preset.value;
      end else if (step) begin
         xd1_ff <= x;
         xd2_ff <= xd1_ff;
         yd1_ff <= y;
         yd2_ff <= yd1_ff;
      end
   end

endmodule

[sv/fixed_point_biquad_iir_top.sv]
// ----------------------------------------------------------------------------
// fixed_point_biquad_iir_top
// Second-order fixed-point IIR, DF1, one sample per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready carry one signed sample per beat; only the low
//   INPUT_WIDTH bits of req_sample are used. rsp_valid/rsp_ready return one
//   16-bit filtered value per beat, in order.
//   csr_wr_en with csr_index and csr_wdata writes a coefficient or the
//   output preset; write only while the filter is idle.
//   Writing the preset loads both output history registers.
// Path: an accepted request beat enters the input register; the filtered
//   value enters the result register, which drives rsp_valid.
// Throughput: one sample per cycle while rsp_ready is high; the input register
//   feeds the five products and the adder into the result and output history.
// Reset: coefficients return to their defaults, input history clears,
//   output history takes the default preset, both stages empty.
// Stall: with rsp_valid high and rsp_ready low the result register holds,
//   an empty input register still takes one more beat, then req_ready drops.
// ----------------------------------------------------------------------------
module fixed_point_biquad_iir_top
   import fbq_pkg::*;
#(
   parameter int INPUT_WIDTH = DEFAULT_INPUT_WIDTH
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [SAMPLE_W-1:0]  req_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OUT_W-1:0]     rsp_filtered,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata
);

   coef_type   coef;
   preset_type preset;

   logic                          x_valid_ff, x_valid_in;
   logic signed [INPUT_WIDTH-1:0] x_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic        [OUT_W-1:0]       rsp_filtered_ff;
   logic        [OUT_W-1:0]       y;
   logic                          step;
   logic                          req_fire;

   fbq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef),
      .preset    (preset)
   );

   fbq_dp #(
      .INPUT_WIDTH (INPUT_WIDTH)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .x      (x_ff),
      .coef   (coef),
      .preset (preset),
      .y      (y)
   );

   assign step      = x_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !x_valid_ff || step;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      x_valid_in   = x_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         x_valid_in = 1'b0;
      end
      if (req_fire) begin
         x_valid_in = 1'b1;
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (step) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x_valid_ff   <= x_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: take a beat, advance the result
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff <= req_sample[INPUT_WIDTH-1:0];
      end
      if (step) begin
         rsp_filtered_ff <= y;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

endmodule
